@@ hdl/btpc_pkg.sv @@
// Shared types, constants and helpers for the barometric compensation block.
`default_nettype none
package btpc_pkg;

    localparam int RAW_W   = 20;
    localparam int CAL_W   = 48;
    localparam int WORD_W  = 32;
    localparam int CENTI_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = WORD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP    = 2'd0,
        CFG_PRESS_A = 2'd1,
        CFG_PRESS_B = 2'd2,
        CFG_PRESS_C = 2'd3
    } t_cfg_idx;

    // Calibration words as stored
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_cal;

    // Temperature results carried alongside the pressure work
    typedef struct packed {
        logic [WORD_W-1:0]  fine;
        logic [CENTI_W-1:0] centi;
    } t_side;

    // Hand-off from the polynomial pipeline to the divider pipeline
    typedef struct packed {
        t_side             side;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } t_front;

    function automatic logic [WORD_W-1:0] f_sx16(input logic [15:0] v);
        f_sx16 = {{(WORD_W-16){v[15]}}, v};
    endfunction

    function automatic logic [WORD_W-1:0] f_asr(input logic [WORD_W-1:0] x, input int n);
        f_asr = $unsigned($signed(x) >>> n);
    endfunction

endpackage
`default_nettype wire

@@ hdl/btpc_raw_if.sv @@
// Input channel: raw temperature and pressure readings.
`default_nettype none
interface btpc_raw_if
    import btpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_temperature;
    logic [RAW_W-1:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface
`default_nettype wire

@@ hdl/btpc_res_if.sv @@
// Output channel: compensated temperature and pressure.
`default_nettype none
interface btpc_res_if
    import btpc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [WORD_W-1:0]  fine_temperature;
    logic signed [CENTI_W-1:0] temperature_centi;
    logic [WORD_W-1:0]         pressure_pa;

    modport source (output valid, output fine_temperature, output temperature_centi,
                    output pressure_pa, input ready);
    modport sink   (input valid, input fine_temperature, input temperature_centi,
                    input pressure_pa, output ready);
endinterface
`default_nettype wire

@@ hdl/baro_temp_press_compensation.sv @@
// Top level: barometric temperature and pressure compensation pipeline.
//
//  channel   dir  fields                                              handshake
//  in_ch     in   raw_temperature, raw_pressure                       valid/ready
//  out_ch    out  fine_temperature, temperature_centi, pressure_pa    valid/ready
//  cfg       in   i_cfg_index, i_cfg_data                             i_cfg_we
//
// One item enters per cycle unless the output stalls; the pipeline has eight
// polynomial, one divider entry, 32 quotient-bit and four final stages.
// Synchronous active-low reset clears all valid bits and calibration registers.
// A stalled output freezes the whole pipeline in place; bubbles keep moving
// only while the last stage is empty or being taken.
`default_nettype none
module baro_temp_press_compensation
    import btpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    btpc_raw_if.sink                  in_ch,
    btpc_res_if.source                out_ch,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CAL_W-1:0]     i_cfg_data
);
    t_cal   cal;
    t_front front;
    t_side  side;
    logic   front_v, adv;

    // Move the pipeline unless the finished transaction is held
    assign adv         = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    btpc_cal_regs u_cal (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cal       (cal)
    );

    btpc_poly_pipe u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (in_ch.valid),
        .i_raw_t (in_ch.raw_temperature),
        .i_raw_p (in_ch.raw_pressure),
        .i_cal   (cal),
        .o_valid (front_v),
        .o_front (front)
    );

    btpc_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (front_v),
        .i_front (front),
        .i_cal   (cal),
        .o_valid (out_ch.valid),
        .o_side  (side),
        .o_press (out_ch.pressure_pa)
    );

    assign out_ch.fine_temperature  = $signed(side.fine);
    assign out_ch.temperature_centi = $signed(side.centi);

`ifndef SYNTH
    logic [WORD_W-1:0] chk_f5, chk_c8;
    assign chk_f5 = (side.fine << 2) + side.fine + 32'd128;
    assign chk_c8 = f_asr(chk_f5, 8);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !out_ch.valid)
        else $error("output valid after reset");

    a_centi_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (side.centi == chk_c8[CENTI_W-1:0]))
        else $error("temperature_centi does not match fine_temperature");

    a_p1_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && (cal.p1 == 16'd0) |-> (out_ch.pressure_pa == '0))
        else $error("zero divisor gave nonzero pressure");
`endif
endmodule
`default_nettype wire

@@ hdl/btpc_cal_regs.sv @@
// Calibration register bank written through the configuration port.
`default_nettype none
module btpc_cal_regs
    import btpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CAL_W-1:0]     i_cfg_data,
    output t_cal                      o_cal
);
    logic [CAL_W-1:0] r_temp, r_pa, r_pb, r_pc;

    // Latch a write into the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_pc   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP:    r_temp <= i_cfg_data;
                CFG_PRESS_A: r_pa   <= i_cfg_data;
                CFG_PRESS_B: r_pb   <= i_cfg_data;
                CFG_PRESS_C: r_pc   <= i_cfg_data;
                default:     r_temp <= r_temp;
            endcase
        end
    end

    // Unpack into calibration words
    always_comb begin
        o_cal.t1 = r_temp[15:0];
        o_cal.t2 = r_temp[31:16];
        o_cal.t3 = r_temp[47:32];
        o_cal.p1 = r_pa[15:0];
        o_cal.p2 = r_pa[31:16];
        o_cal.p3 = r_pa[47:32];
        o_cal.p4 = r_pb[15:0];
        o_cal.p5 = r_pb[31:16];
        o_cal.p6 = r_pb[47:32];
        o_cal.p7 = r_pc[15:0];
        o_cal.p8 = r_pc[31:16];
        o_cal.p9 = r_pc[47:32];
    end
endmodule
`default_nettype wire

@@ hdl/btpc_poly_pipe.sv @@
// Eight-stage pipeline for the temperature and pressure polynomials.
`default_nettype none
module btpc_poly_pipe
    import btpc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_valid,
    input  wire logic [RAW_W-1:0] i_raw_t,
    input  wire logic [RAW_W-1:0] i_raw_p,
    input  t_cal                  i_cal,
    output logic                  o_valid,
    output t_front                o_front
);
    localparam int NST = 8;

    logic [NST:1]      r_v;
    logic [RAW_W-1:0]  r_adcp [1:7];
    t_side             r_side [4:8];
    logic [WORD_W-1:0] r1_x1, r1_dd, r2_a, r2_e, r3_fine;
    logic [WORD_W-1:0] r4_sq, r4_ap5, r4_p2a, r5_b1, r5_b2, r5_ap5, r5_p2a;
    logic [WORD_W-1:0] r6_b, r6_a, r7_m, r7_b, r8_av, r8_pr;

    logic [WORD_W-1:0] n_adct, n_d, n_f5, n_c8, n_pa, n_q, n_m8;

    // Operands for stages one, four and eight
    always_comb begin
        n_adct = {{(WORD_W-RAW_W){1'b0}}, i_raw_t};
        n_d    = (n_adct >> 4) - {16'b0, i_cal.t1};
        n_f5   = (r3_fine << 2) + r3_fine + 32'd128;
        n_c8   = f_asr(n_f5, 8);
        n_pa   = f_asr(r3_fine, 1) - 32'd64000;
        n_q    = f_asr(n_pa, 2);
        n_m8   = 32'h0010_0000 - {{(WORD_W-RAW_W){1'b0}}, r_adcp[7]} - f_asr(r7_b, 12);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[NST-1:1], i_valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // temperature products
            r_adcp[1] <= i_raw_p;
            r1_x1 <= ((n_adct >> 3) - {15'b0, i_cal.t1, 1'b0}) * f_sx16(i_cal.t2);
            r1_dd <= n_d * n_d;
            r_adcp[2] <= r_adcp[1];
            r2_a  <= f_asr(r1_x1, 11);
            r2_e  <= f_asr(r1_dd, 12) * f_sx16(i_cal.t3);
            r_adcp[3] <= r_adcp[2];
            r3_fine <= r2_a + f_asr(r2_e, 14);
            // pressure first terms
            r_adcp[4] <= r_adcp[3];
            r_side[4].fine  <= r3_fine;
            r_side[4].centi <= n_c8[CENTI_W-1:0];
            r4_sq  <= n_q * n_q;
            r4_ap5 <= n_pa * f_sx16(i_cal.p5);
            r4_p2a <= f_sx16(i_cal.p2) * n_pa;
            r_adcp[5] <= r_adcp[4];
            r_side[5] <= r_side[4];
            r5_b1  <= f_asr(r4_sq, 11) * f_sx16(i_cal.p6);
            r5_b2  <= f_sx16(i_cal.p3) * f_asr(r4_sq, 13);
            r5_ap5 <= r4_ap5;
            r5_p2a <= r4_p2a;
            r_adcp[6] <= r_adcp[5];
            r_side[6] <= r_side[5];
            r6_b <= f_asr(r5_b1 + (r5_ap5 << 1), 2) + (f_sx16(i_cal.p4) << 16);
            r6_a <= f_asr(f_asr(r5_b2, 3) + f_asr(r5_p2a, 1), 18);
            // divisor and dividend
            r_adcp[7] <= r_adcp[6];
            r_side[7] <= r_side[6];
            r7_m <= (32'd32768 + r6_a) * {16'b0, i_cal.p1};
            r7_b <= r6_b;
            r_side[8] <= r_side[7];
            r8_av <= f_asr(r7_m, 15);
            r8_pr <= n_m8 * 32'd3125;
        end
    end

    assign o_valid       = r_v[NST];
    assign o_front.side  = r_side[8];
    assign o_front.num   = r8_pr;
    assign o_front.den   = r8_av;
endmodule
`default_nettype wire

@@ hdl/btpc_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit a stage, and the final pressure terms.
`default_nettype none
module btpc_div_pipe
    import btpc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic                i_valid,
    input  t_front                   i_front,
    input  t_cal                     i_cal,
    output logic                     o_valid,
    output t_side                    o_side,
    output logic [WORD_W-1:0]        o_press
);
    localparam int NPOST = 4;

    logic [DIV_STEPS:0]  r_v;
    logic [WORD_W-1:0]   r_rem  [0:DIV_STEPS];
    logic [WORD_W-1:0]   r_num  [0:DIV_STEPS];
    logic [WORD_W-1:0]   r_den  [0:DIV_STEPS];
    logic                r_zero [0:DIV_STEPS];
    logic                r_dbl  [0:DIV_STEPS];
    t_side               r_side [0:DIV_STEPS];

    logic [NPOST:1]      r_pv;
    t_side               r_ps   [1:NPOST];
    logic                r_pz   [1:NPOST-1];
    logic [WORD_W-1:0]   r_ppr  [1:NPOST-1];
    logic [WORD_W-1:0]   r2_qq, r2_m8, r3_a, r3_b, r4_out;
    logic [WORD_W-1:0]   n_q, n_sum;

    // Entry: order of doubling set by the dividend bound
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]  <= '0;
            r_den[0]  <= i_front.den;
            r_zero[0] <= (i_front.den == '0);
            r_dbl[0]  <= i_front.num[WORD_W-1];
            r_num[0]  <= i_front.num[WORD_W-1] ? i_front.num : (i_front.num << 1);
            r_side[0] <= i_front.side;
        end
    end

    // One quotient bit a stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [WORD_W:0] n_try;
        logic            n_ge;
        always_comb begin
            n_try = {r_rem[k], r_num[k][WORD_W-1]};
            n_ge  = (n_try >= {1'b0, r_den[k]});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[k+1] <= r_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k+1]  <= n_ge ? (n_try[WORD_W-1:0] - r_den[k]) : n_try[WORD_W-1:0];
                r_num[k+1]  <= {r_num[k][WORD_W-2:0], n_ge};
                r_den[k+1]  <= r_den[k];
                r_zero[k+1] <= r_zero[k];
                r_dbl[k+1]  <= r_dbl[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_comb begin
        n_q   = r_ppr[1] >> 3;
        n_sum = r3_a + r3_b + f_sx16(i_cal.p7);
    end

    // Post-division valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (i_adv) begin
            r_pv <= {r_pv[NPOST-1:1], r_v[DIV_STEPS]};
        end
    end

    // Scale quotient, then the two correction terms, then the sum, forced to zero for a zero divisor
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ps[1]  <= r_side[DIV_STEPS];
            r_pz[1]  <= r_zero[DIV_STEPS];
            r_ppr[1] <= r_dbl[DIV_STEPS] ? (r_num[DIV_STEPS] << 1) : r_num[DIV_STEPS];
            r_ps[2]  <= r_ps[1];
            r_pz[2]  <= r_pz[1];
            r_ppr[2] <= r_ppr[1];
            r2_qq    <= (n_q * n_q) >> 13;
            r2_m8    <= (r_ppr[1] >> 2) * f_sx16(i_cal.p8);
            r_ps[3]  <= r_ps[2];
            r_pz[3]  <= r_pz[2];
            r_ppr[3] <= r_ppr[2];
            r3_a     <= f_asr(f_sx16(i_cal.p9) * r2_qq, 12);
            r3_b     <= f_asr(r2_m8, 13);
            r_ps[4]  <= r_ps[3];
            r4_out   <= r_pz[3] ? '0 : (r_ppr[3] + f_asr(n_sum, 4));
        end
    end

    assign o_valid = r_pv[NPOST];
    assign o_side  = r_ps[NPOST];
    assign o_press = r4_out;
endmodule
`default_nettype wire

@@ bench/btpc_compensation_checker.sv @@
// Checker: tracks calibration writes, predicts compensated outputs, compares results.
module btpc_compensation_checker
    import btpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic [RAW_W-1:0]     i_raw_temperature,
    input  wire logic [RAW_W-1:0]     i_raw_pressure,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic [WORD_W-1:0]    i_fine_temperature,
    input  wire logic [CENTI_W-1:0]   i_temperature_centi,
    input  wire logic [WORD_W-1:0]    i_pressure_pa,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CAL_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic [WORD_W-1:0]  fine;
        logic [CENTI_W-1:0] centi;
        logic [WORD_W-1:0]  press;
    } t_comp;

    logic [CAL_W-1:0] cal_temp, cal_pa, cal_pb, cal_pc;
    t_comp            comp_expected_q[$];

    assign o_pending = comp_expected_q.size();

    function automatic bit [31:0] sra(input bit [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic bit [31:0] word_u(input logic [CAL_W-1:0] r, input int k);
        return {16'd0, r[16*k +: 16]};
    endfunction

    function automatic bit [31:0] word_s(input logic [CAL_W-1:0] r, input int k);
        return {{16{r[16*k+15]}}, r[16*k +: 16]};
    endfunction

    // Run the temperature path, then the pressure path with the same fine value
    function automatic t_comp compensate(input bit [19:0] adc_t, input bit [19:0] adc_p);
        bit [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        bit [31:0] a, b, d, fine, centi, pr, q, sq;
        t_comp     r;
        t1 = word_u(cal_temp, 0); t2 = word_s(cal_temp, 1); t3 = word_s(cal_temp, 2);
        p1 = word_u(cal_pa, 0);   p2 = word_s(cal_pa, 1);   p3 = word_s(cal_pa, 2);
        p4 = word_s(cal_pb, 0);   p5 = word_s(cal_pb, 1);   p6 = word_s(cal_pb, 2);
        p7 = word_s(cal_pc, 0);   p8 = word_s(cal_pc, 1);   p9 = word_s(cal_pc, 2);
        a = sra(((32'(adc_t) >> 3) - (t1 << 1)) * t2, 11);
        d = (32'(adc_t) >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        fine = a + b;
        centi = sra(fine * 32'd5 + 32'd128, 8);
        a = sra(fine, 1) - 32'd64000;
        q = sra(a, 2);
        sq = q * q;
        b = sra(sq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * a, 1), 18);
        a = sra((32'd32768 + a) * p1, 15);
        if (a == 0) begin
            pr = 0;
        end else begin
            pr = ((32'h100000 - 32'(adc_p)) - sra(b, 12)) * 32'd3125;
            if (pr < 32'h80000000) pr = (pr << 1) / a;
            else pr = (pr / a) * 32'd2;
            q = pr >> 3;
            a = sra(p9 * ((q * q) >> 13), 12);
            b = sra((pr >> 2) * p8, 13);
            pr = pr + sra(a + b + p7, 4);
        end
        r.fine = fine;
        r.centi = centi[23:0];
        r.press = pr;
        return r;
    endfunction

    // Track calibration, queue predictions, compare results
    always @(posedge i_clk) begin
        t_comp e;
        if (!i_rst_n) begin
            cal_temp <= '0; cal_pa <= '0; cal_pb <= '0; cal_pc <= '0;
            comp_expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TEMP:    cal_temp <= i_cfg_data;
                    CFG_PRESS_A: cal_pa <= i_cfg_data;
                    CFG_PRESS_B: cal_pb <= i_cfg_data;
                    CFG_PRESS_C: cal_pc <= i_cfg_data;
                endcase
            end
            if (i_in_valid && i_in_ready)
                comp_expected_q.push_back(compensate(i_raw_temperature, i_raw_pressure));
            if (i_out_valid && i_out_ready) begin
                if (comp_expected_q.size() == 0) begin
                    $display("%0t unexpected result fine=%h centi=%h press=%h", $time,
                             i_fine_temperature, i_temperature_centi, i_pressure_pa);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = comp_expected_q.pop_front();
                    if (e.fine !== i_fine_temperature || e.centi !== i_temperature_centi ||
                        e.press !== i_pressure_pa) begin
                        $display("%0t mismatch expected fine=%h centi=%h press=%h", $time,
                                 e.fine, e.centi, e.press);
                        $display("%0t          actual   fine=%h centi=%h press=%h", $time,
                                 i_fine_temperature, i_temperature_centi, i_pressure_pa);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ bench/baro_temp_press_compensation_test.sv @@
// Testbench top: stimulus, calibration phases and verdict for the compensation block.
module baro_temp_press_compensation_test;
    import btpc_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TEMP;
    logic [CAL_W-1:0]     i_cfg_data = '0;
    int                   fail_count;
    int                   pending;
    bit                   sink_on = 1'b0;

    btpc_raw_if raw_ch();
    btpc_res_if res_ch();

    initial begin
        raw_ch.valid = 1'b0;
        raw_ch.raw_temperature = '0;
        raw_ch.raw_pressure = '0;
        res_ch.ready = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    baro_temp_press_compensation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(raw_ch.sink), .out_ch(res_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    btpc_compensation_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(raw_ch.valid), .i_in_ready(raw_ch.ready),
        .i_raw_temperature(raw_ch.raw_temperature), .i_raw_pressure(raw_ch.raw_pressure),
        .i_out_valid(res_ch.valid), .i_out_ready(res_ch.ready),
        .i_fine_temperature(res_ch.fine_temperature),
        .i_temperature_centi(res_ch.temperature_centi), .i_pressure_pa(res_ch.pressure_pa),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Result side: random stalls drawn per transaction, some transactions taken without a stall
    always @(posedge i_clk) begin
        int stall;
        if (sink_on) begin
            if (res_ch.ready && res_ch.valid) begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                if (stall > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    res_ch.ready <= 1'b1;
                end
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_cal(input t_cfg_idx idx, input logic [CAL_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Send one reading pair, holding valid until accepted
    task automatic send_reading(input logic [19:0] t, input logic [19:0] p, input int gap);
        if (gap > 0) begin
            raw_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        raw_ch.valid <= 1'b1;
        raw_ch.raw_temperature <= t;
        raw_ch.raw_pressure <= p;
        @(posedge i_clk);
        while (!raw_ch.ready) @(posedge i_clk);
    endtask

    // Wait until every expected result has arrived
    task automatic drain();
        raw_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Realistic calibration near typical sensor values, with random spread
    task automatic load_typical();
        write_cal(CFG_TEMP, {16'($urandom_range(0, 100)), 16'(26000 + $urandom_range(0, 2000)),
                             16'(27000 + $urandom_range(0, 2000))});
        write_cal(CFG_PRESS_A, {16'(16'hf000 + $urandom_range(0, 2000)),
                                16'(-16'sd10600 + $urandom_range(0, 1000)),
                                16'(36000 + $urandom_range(0, 2000))});
        write_cal(CFG_PRESS_B, {16'(-16'sd7 + $urandom_range(0, 14)),
                                16'(-16'sd10 + $urandom_range(0, 300)),
                                16'(2800 + $urandom_range(0, 600))});
        write_cal(CFG_PRESS_C, {16'(6000 + $urandom_range(0, 300)),
                                16'(-16'sd14600 + $urandom_range(0, 300)),
                                16'($urandom_range(0, 40))});
    endtask

    task automatic load_random();
        write_cal(CFG_TEMP, CAL_W'({$urandom(), $urandom()}));
        write_cal(CFG_PRESS_A, CAL_W'({$urandom(), $urandom()}));
        write_cal(CFG_PRESS_B, CAL_W'({$urandom(), $urandom()}));
        write_cal(CFG_PRESS_C, CAL_W'({$urandom(), $urandom()}));
    endtask

    task automatic random_burst(input int count, input bit typical_raw);
        logic [19:0] t, p;
        int          gap;
        for (int k = 0; k < count; k++) begin
            if (typical_raw && $urandom_range(0, 4) != 0) begin
                t = 20'(400000 + $urandom_range(0, 200000));
                p = 20'(250000 + $urandom_range(0, 200000));
            end else begin
                t = 20'($urandom());
                p = 20'($urandom());
            end
            gap = ((k / 40) % 3 == 0) ? 0 : $urandom_range(0, 14);
            send_reading(t, p, gap);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: zero divisor everywhere
        send_reading(20'h00000, 20'h00000, 0);
        send_reading(20'hfffff, 20'hfffff, 0);
        drain();

        // Extremes of calibration and readings
        write_cal(CFG_TEMP, '1);
        write_cal(CFG_PRESS_A, '1);
        write_cal(CFG_PRESS_B, '1);
        write_cal(CFG_PRESS_C, '1);
        send_reading(20'h00000, 20'hfffff, 0);
        send_reading(20'hfffff, 20'h00000, 1);
        send_reading(20'h80000, 20'h80000, 0);
        send_reading(20'h55555, 20'haaaaa, 0);
        drain();
        write_cal(CFG_TEMP, 48'h8000_8000_7fff);
        write_cal(CFG_PRESS_A, 48'h8000_7fff_ffff);
        write_cal(CFG_PRESS_B, 48'h7fff_8000_7fff);
        write_cal(CFG_PRESS_C, 48'h8000_7fff_8000);
        send_reading(20'h00000, 20'h00000, 0);
        send_reading(20'hfffff, 20'hfffff, 0);
        send_reading(20'haaaaa, 20'h55555, 0);
        drain();

        // Typical calibration: both division orders and the correction terms
        load_typical();
        send_reading(20'd519888, 20'd415148, 0);
        send_reading(20'd519888, 20'd0, 0);
        send_reading(20'd519888, 20'hfffff, 0);
        send_reading(20'd0, 20'd300000, 0);
        send_reading(20'hfffff, 20'd300000, 0);
        drain();

        // Random phases: arbitrary calibration every third phase, typical calibration otherwise
        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 3 == 2) load_random();
            else load_typical();
            random_burst(53, ph % 3 != 2);
            drain();
        end

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
